// ----- rtl/tcfe_pkg.sv -----
// Shared types, frame layout constants and small helper functions for the
// time-code frame encoder. No dependencies.
`default_nettype none

package tcfe_pkg;

    // Input field widths
    localparam int MINUTE_W = 6;
    localparam int HOUR_W   = 5;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 7;

    // Result field widths
    localparam int FRAME_W   = 59;
    localparam int WEEKDAY_W = 3;

    // Packed field widths and stream widths (stream widths in whole bytes)
    localparam int IN_FIELDS_W  = MINUTE_W + HOUR_W + DAY_W + MONTH_W + YEAR_W;
    localparam int OUT_FIELDS_W = FRAME_W + WEEKDAY_W;
    localparam int S_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Frame bit positions
    localparam int START_BIT    = 20;
    localparam int MINUTE_LSB   = 21;
    localparam int MINUTE_PAR   = 28;
    localparam int HOUR_LSB     = 29;
    localparam int HOUR_PAR     = 35;
    localparam int DAY_LSB      = 36;
    localparam int WEEKDAY_LSB  = 42;
    localparam int MONTH_LSB    = 45;
    localparam int YEAR_LSB     = 50;
    localparam int DATE_PAR     = 58;

    // Sunday comes out of the rule as zero, output as seven
    localparam logic [WEEKDAY_W-1:0] SUNDAY = 3'd7;

    // Month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [YEAR_W-1:0]   year_in_century;
        logic [MONTH_W-1:0]  month_value;
        logic [DAY_W-1:0]    day_of_month;
        logic [HOUR_W-1:0]   hour_value;
        logic [MINUTE_W-1:0] minute_value;
    } time_fields_t;

    typedef struct packed {
        logic [WEEKDAY_W-1:0] weekday_value;
        logic [FRAME_W-1:0]   frame_bits;
    } frame_result_t;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } bcd_pair_t;

    // Split 0..127 into tens and units: tens = v*205 >> 11 is exact here
    function automatic bcd_pair_t bcd_split(input logic [6:0] v);
        logic [14:0] prod;
        logic [6:0]  tens_x10;
        logic [6:0]  diff;
        bcd_pair_t   res;
        prod     = {8'd0, v} * 15'd205;
        res.tens = prod[14:11];
        tens_x10 = {res.tens[3:0], 3'b000} + {2'b00, res.tens[3:0], 1'b0};
        diff     = v - tens_x10;
        res.units = diff[3:0];
        return res;
    endfunction

    // Sakamoto month offsets; anything outside 1..12 reads as January
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/time_code_frame_encoder_unit.sv -----
// Top level of the time-code frame encoder: input register, frame logic,
// result register. Depends on tcfe_pkg, tcfe_weekday, tcfe_frame_build.
//
//  Channel  Dir  Width  Contents (low bit first)
//  s_       in   32     minute 6, hour 5, day 5, month 4, year 7, zero pad
//  m_       out  64     frame 59, weekday 3, zero pad
//
// A request goes through the input register, then the result register.
// One request per cycle is sustained while m_tready is high; the weekday
// fold-and-compare path between the two registers sets the clock limit.
// aresetn (synchronous) clears both stage valid flags; data is not reset.
// A stall on m_ holds the result; s_tready stays high while the input
// stage is empty or moving on, so both stages stay full under stall.
`default_nettype none

module time_code_frame_encoder_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // minute_value[5:0], hour_value[10:6], day_of_month[15:11],
    // month_value[19:16], year_in_century[26:20], zeros above
    input  wire logic [tcfe_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // frame_bits[58:0], weekday_value[61:59], zeros above
    output logic      [tcfe_pkg::M_TDATA_W-1:0]  m_tdata
);

    // Input stage
    logic                   in_valid_reg;
    tcfe_pkg::time_fields_t in_fields_reg;

    // Result stage
    logic                    out_valid_reg;
    tcfe_pkg::frame_result_t out_result_reg;
    tcfe_pkg::frame_result_t out_result_next;

    logic out_load;
    logic in_load;

    // Result stage takes a new value when empty or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_fields_reg <= tcfe_pkg::time_fields_t'(s_tdata[tcfe_pkg::IN_FIELDS_W-1:0]);
        end
        if (out_load && in_valid_reg) begin
            out_result_reg <= out_result_next;
        end
    end

    tcfe_weekday u_weekday (
        .day_of_month    (in_fields_reg.day_of_month),
        .month_value     (in_fields_reg.month_value),
        .year_in_century (in_fields_reg.year_in_century),
        .weekday_value   (out_result_next.weekday_value)
    );

    tcfe_frame_build u_frame_build (
        .fields        (in_fields_reg),
        .weekday_value (out_result_next.weekday_value),
        .frame_bits    (out_result_next.frame_bits)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tcfe_pkg::M_TDATA_W - tcfe_pkg::OUT_FIELDS_W){1'b0}}, out_result_reg};

endmodule

`default_nettype wire

// ----- rtl/tcfe_weekday.sv -----
// Day-of-week for 2000 + year_in_century by Sakamoto's rule, no dividers.
// Depends on tcfe_pkg.
`default_nettype none

module tcfe_weekday (
    input  wire logic [tcfe_pkg::DAY_W-1:0]     day_of_month,
    input  wire logic [tcfe_pkg::MONTH_W-1:0]   month_value,
    input  wire logic [tcfe_pkg::YEAR_W-1:0]    year_in_century,
    output logic      [tcfe_pkg::WEEKDAY_W-1:0] weekday_value
);

    // y = 2000 + k; y + y/4 - y/100 + y/400 = 2485 + k + k/4 - (k >= 100),
    // and 2485 is a multiple of 7. Year 1999 (k = -1) folds to 5.
    logic        jan_feb;
    logic [6:0]  k;
    logic [7:0]  base;
    logic [7:0]  total;
    logic [4:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  rem7;

    always_comb begin
        jan_feb = (month_value <= tcfe_pkg::MONTH_FEB) ||
                  (month_value >  tcfe_pkg::MONTH_DEC);
        k = year_in_century - {6'd0, jan_feb};
        if (jan_feb && (year_in_century == '0)) begin
            base = 8'd5;
        end else begin
            base = {1'b0, k} + {3'd0, k[6:2]} - {7'd0, (k >= 7'd100)};
        end
        total = base + {5'd0, tcfe_pkg::month_offset(month_value)}
                     + {3'd0, day_of_month};
        // 8 = 1 mod 7: sum octal digits, twice, then one correction
        fold1 = {3'd0, total[7:6]} + {2'd0, total[5:3]} + {2'd0, total[2:0]};
        fold2 = {2'd0, fold1[4:3]} + {1'b0, fold1[2:0]};
        if (fold2 >= 4'd7) begin
            fold2 = fold2 - 4'd7;
        end
        rem7 = fold2[2:0];
        weekday_value = (rem7 == 3'd0) ? tcfe_pkg::SUNDAY : rem7;
    end

endmodule

`default_nettype wire

// ----- rtl/tcfe_frame_build.sv -----
// Assembles the 59-bit frame: start bit, BCD groups, weekday and even parity bits.
// Depends on tcfe_pkg.
`default_nettype none

module tcfe_frame_build (
    input  wire tcfe_pkg::time_fields_t         fields,
    input  wire logic [tcfe_pkg::WEEKDAY_W-1:0] weekday_value,
    output logic      [tcfe_pkg::FRAME_W-1:0]   frame_bits
);

    tcfe_pkg::bcd_pair_t minute_bcd;
    tcfe_pkg::bcd_pair_t hour_bcd;
    tcfe_pkg::bcd_pair_t day_bcd;
    tcfe_pkg::bcd_pair_t month_bcd;
    tcfe_pkg::bcd_pair_t year_bcd;

    always_comb begin
        minute_bcd = tcfe_pkg::bcd_split({1'b0, fields.minute_value});
        hour_bcd   = tcfe_pkg::bcd_split({2'b00, fields.hour_value});
        day_bcd    = tcfe_pkg::bcd_split({2'b00, fields.day_of_month});
        month_bcd  = tcfe_pkg::bcd_split({3'b000, fields.month_value});
        year_bcd   = tcfe_pkg::bcd_split(fields.year_in_century);

        frame_bits = '0;
        frame_bits[tcfe_pkg::START_BIT] = 1'b1;
        frame_bits[tcfe_pkg::MINUTE_LSB +: 7] = {minute_bcd.tens[2:0], minute_bcd.units};
        frame_bits[tcfe_pkg::HOUR_LSB +: 6]   = {hour_bcd.tens[1:0], hour_bcd.units};
        frame_bits[tcfe_pkg::DAY_LSB +: 6]    = {day_bcd.tens[1:0], day_bcd.units};
        frame_bits[tcfe_pkg::WEEKDAY_LSB +: 3] = weekday_value;
        frame_bits[tcfe_pkg::MONTH_LSB +: 5]  = {month_bcd.tens[0], month_bcd.units};
        frame_bits[tcfe_pkg::YEAR_LSB +: 8]   = {year_bcd.tens, year_bcd.units};

        frame_bits[tcfe_pkg::MINUTE_PAR] = ^frame_bits[tcfe_pkg::MINUTE_PAR-1:tcfe_pkg::MINUTE_LSB];
        frame_bits[tcfe_pkg::HOUR_PAR]   = ^frame_bits[tcfe_pkg::HOUR_PAR-1:tcfe_pkg::HOUR_LSB];
        frame_bits[tcfe_pkg::DATE_PAR]   = ^frame_bits[tcfe_pkg::DATE_PAR-1:tcfe_pkg::DAY_LSB];
    end

endmodule

`default_nettype wire
